[rtl/color_window_line_position_assert.svh]
// ---------------------------------------------------------------------------
// colour window line position: assertion macros
// shared property forms for the port checker, sampled on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef COLOR_WINDOW_LINE_POSITION_ASSERT_SVH
`define COLOR_WINDOW_LINE_POSITION_ASSERT_SVH

// same-cycle implication
`define CWLP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CWLP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cwlp_pkg.sv]
// ---------------------------------------------------------------------------
// cwlp_pkg
// types and fixed constants of the colour window line position block
// ---------------------------------------------------------------------------
package cwlp_pkg;

  localparam int MAX_SENSORS = 5;
  localparam int SENSOR_W    = 10;
  localparam int BOUND_W     = 11;
  localparam int PACK_W      = MAX_SENSORS * BOUND_W;
  localparam int CFG_DATA_W  = PACK_W;
  localparam int CFG_IDX_W   = 3;
  localparam int WEIGHT_W    = 13;  // reading times outer gain, 1023 * 6
  localparam int PLACE_W     = 13;  // sensor place, up to 5000
  localparam int MOMENT_W    = WEIGHT_W + PLACE_W;
  localparam int WSUM_W      = 14;  // two outer lanes at gain plus three plain
  localparam int MSUM_W      = 26;
  localparam int POS_W       = 13;
  localparam int DIV_W       = MSUM_W + 1;
  localparam int SPACING     = 1000;
  localparam int EDGE_GAIN   = 6;
  localparam int LATENCY     = POS_W + 2;  // lane, merge, one divider stage per bit

  localparam logic [BOUND_W-1:0] BLACK_LOW_RESET  = 11'd300;
  localparam logic [BOUND_W-1:0] BLACK_HIGH_RESET = 11'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLACK_LOW       = 3'd0,
    CFG_BLACK_HIGH      = 3'd1,
    CFG_GREEN_LOW_PACK  = 3'd2,
    CFG_GREEN_HIGH_PACK = 3'd3,
    CFG_BROWN_LOW_PACK  = 3'd4,
    CFG_BROWN_HIGH_PACK = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_0;
    logic [SENSOR_W-1:0] sensor_1;
    logic [SENSOR_W-1:0] sensor_2;
    logic [SENSOR_W-1:0] sensor_3;
    logic [SENSOR_W-1:0] sensor_4;
  } frame_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             line_found;
    logic             green_line;
    logic             brown_seen;
  } result_t;

  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
  } window_t;

  typedef struct packed {
    logic                hit;
    logic                green;
    logic                brown;
    logic [WEIGHT_W-1:0] weight;
    logic [MOMENT_W-1:0] moment;
  } lane_out_t;

  typedef struct packed {
    logic              found;
    logic              green;
    logic              brown;
    logic [WSUM_W-1:0] wsum;
    logic [MSUM_W-1:0] msum;
  } merge_out_t;

  typedef struct packed {
    logic [MSUM_W-1:0] rem;
    logic [WSUM_W-1:0] divisor;
    logic [POS_W-1:0]  quot;
    logic              found;
    logic              green;
    logic              brown;
  } div_stage_t;

endpackage

[rtl/color_window_line_position.sv]
// ---------------------------------------------------------------------------
// color_window_line_position
// line position from a reflectance array with black, green and brown windows
// ---------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// frame     in         start high, busy low   cwlp_pkg::frame_t, five readings
// result    out        done strobe, 1 cycle   cwlp_pkg::result_t
// cfg       in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// one frame per clock while busy is low; a result passes one lane stage, one
// merge stage and thirteen divider stages, one per quotient bit, on its way
// to the ports; LATENCY in cwlp_pkg counts these stages
// synchronous reset clears the stage valids and loads the window registers;
// busy is high for the cycle after each reset cycle and low otherwise
// the result side has no back-pressure, done and result last one cycle
// ---------------------------------------------------------------------------
module color_window_line_position #(
  parameter int NUM_SENSORS = 5
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // frame channel
  input  logic                                   start,
  output logic                                   busy,
  input  cwlp_pkg::frame_t                       frame,
  // result channel
  output logic                                   done,
  output cwlp_pkg::result_t                      result,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cwlp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cwlp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // window registers
  logic [cwlp_pkg::BOUND_W-1:0] black_low;
  logic [cwlp_pkg::BOUND_W-1:0] black_high;
  logic [cwlp_pkg::PACK_W-1:0]  green_low_pack;
  logic [cwlp_pkg::PACK_W-1:0]  green_high_pack;
  logic [cwlp_pkg::PACK_W-1:0]  brown_low_pack;
  logic [cwlp_pkg::PACK_W-1:0]  brown_high_pack;

  logic                          accept;
  logic                          lane_valid;
  logic [cwlp_pkg::SENSOR_W-1:0] reading [cwlp_pkg::MAX_SENSORS];
  cwlp_pkg::window_t             black_win;
  cwlp_pkg::lane_out_t           lane_res [NUM_SENSORS];
  logic                          merge_valid;
  cwlp_pkg::merge_out_t          merged;

  // configuration writes are always taken; indexes past the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_low       <= cwlp_pkg::BLACK_LOW_RESET;
      black_high      <= cwlp_pkg::BLACK_HIGH_RESET;
      green_low_pack  <= '0;
      green_high_pack <= '0;
      brown_low_pack  <= '0;
      brown_high_pack <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cwlp_pkg::cfg_index_t'(cfg_index))
        cwlp_pkg::CFG_BLACK_LOW:       black_low       <= cfg_data[cwlp_pkg::BOUND_W-1:0];
        cwlp_pkg::CFG_BLACK_HIGH:      black_high      <= cfg_data[cwlp_pkg::BOUND_W-1:0];
        cwlp_pkg::CFG_GREEN_LOW_PACK:  green_low_pack  <= cfg_data;
        cwlp_pkg::CFG_GREEN_HIGH_PACK: green_high_pack <= cfg_data;
        cwlp_pkg::CFG_BROWN_LOW_PACK:  brown_low_pack  <= cfg_data;
        cwlp_pkg::CFG_BROWN_HIGH_PACK: brown_high_pack <= cfg_data;
        default: ;
      endcase
    end
  end

  // the pipeline never stalls, busy is a registered copy of rst
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else begin
      lane_valid <= accept;
    end
  end

  // readings by sensor number, sensor 0 leftmost
  assign reading[0] = frame.sensor_0;
  assign reading[1] = frame.sensor_1;
  assign reading[2] = frame.sensor_2;
  assign reading[3] = frame.sensor_3;
  assign reading[4] = frame.sensor_4;

  assign black_win.lo = black_low;
  assign black_win.hi = black_high;

  // one lane per sensor; the two end lanes take the green gain
  for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
    localparam logic [cwlp_pkg::PLACE_W-1:0] PLACE =
      cwlp_pkg::PLACE_W'((i + 1) * cwlp_pkg::SPACING);
    localparam logic OUTER = (i == 0) || (i == NUM_SENSORS - 1);

    cwlp_pkg::window_t green_win;
    cwlp_pkg::window_t brown_win;

    assign green_win.lo = green_low_pack[i*cwlp_pkg::BOUND_W +: cwlp_pkg::BOUND_W];
    assign green_win.hi = green_high_pack[i*cwlp_pkg::BOUND_W +: cwlp_pkg::BOUND_W];
    assign brown_win.lo = brown_low_pack[i*cwlp_pkg::BOUND_W +: cwlp_pkg::BOUND_W];
    assign brown_win.hi = brown_high_pack[i*cwlp_pkg::BOUND_W +: cwlp_pkg::BOUND_W];

    cwlp_lane u_lane (
      .clk      (clk),
      .value    (reading[i]),
      .outer    (OUTER),
      .place    (PLACE),
      .black    (black_win),
      .green    (green_win),
      .brown    (brown_win),
      .lane_out (lane_res[i])
    );
  end

  // sums and flags across the lanes
  cwlp_merge #(
    .NUM_LANES (NUM_SENSORS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lane_valid),
    .lanes     (lane_res),
    .out_valid (merge_valid),
    .merged    (merged)
  );

  // centroid: moment sum over weight sum, truncated
  cwlp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (merge_valid),
    .merged   (merged),
    .done     (done),
    .result   (result)
  );

endmodule

[rtl/cwlp_lane.sv]
// ---------------------------------------------------------------------------
// cwlp_lane
// one sensor: window checks, weight and moment, registered
// ---------------------------------------------------------------------------
module cwlp_lane (
  input  logic                                 clk,
  input  logic [cwlp_pkg::SENSOR_W-1:0]        value,
  input  logic                                 outer,
  input  logic [cwlp_pkg::PLACE_W-1:0]         place,
  input  cwlp_pkg::window_t                    black,
  input  cwlp_pkg::window_t                    green,
  input  cwlp_pkg::window_t                    brown,
  output cwlp_pkg::lane_out_t                  lane_out
);

  logic [cwlp_pkg::BOUND_W-1:0]  v_ext;
  logic                          in_black;
  logic                          in_green;
  logic                          in_brown;
  logic [cwlp_pkg::WEIGHT_W-1:0] weight;
  cwlp_pkg::lane_out_t           lane_next;

  assign v_ext = cwlp_pkg::BOUND_W'(value);

  // inclusive bounds, an inverted window holds nothing
  assign in_black = (v_ext >= black.lo) && (v_ext <= black.hi);
  assign in_green = (v_ext >= green.lo) && (v_ext <= green.hi);
  assign in_brown = (v_ext >= brown.lo) && (v_ext <= brown.hi);

  always_comb begin
    if (in_green && outer) begin
      weight = cwlp_pkg::WEIGHT_W'(value * cwlp_pkg::EDGE_GAIN);
    end else if (in_green || in_black) begin
      weight = cwlp_pkg::WEIGHT_W'(value);
    end else begin
      weight = '0;
    end
  end

  always_comb begin
    lane_next.hit    = in_black || in_green;
    lane_next.green  = in_green;
    lane_next.brown  = in_brown;
    lane_next.weight = weight;
    lane_next.moment = cwlp_pkg::MOMENT_W'(weight * place);
  end

  always_ff @(posedge clk) begin
    lane_out <= lane_next;
  end

endmodule

[rtl/cwlp_merge.sv]
// ---------------------------------------------------------------------------
// cwlp_merge
// combines lane results: weight and moment sums, flags
// ---------------------------------------------------------------------------
module cwlp_merge #(
  parameter int NUM_LANES = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  cwlp_pkg::lane_out_t   lanes [NUM_LANES],
  output logic                  out_valid,
  output cwlp_pkg::merge_out_t  merged
);

  cwlp_pkg::merge_out_t merged_next;
  logic                 any_hit;

  always_comb begin
    merged_next.wsum  = '0;
    merged_next.msum  = '0;
    merged_next.green = 1'b0;
    merged_next.brown = 1'b1;
    any_hit           = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      merged_next.wsum  = merged_next.wsum + cwlp_pkg::WSUM_W'(lanes[i].weight);
      merged_next.msum  = merged_next.msum + cwlp_pkg::MSUM_W'(lanes[i].moment);
      merged_next.green = merged_next.green | lanes[i].green;
      merged_next.brown = merged_next.brown & lanes[i].brown;
      any_hit           = any_hit | lanes[i].hit;
    end
    merged_next.found = any_hit && (merged_next.wsum != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    merged <= merged_next;
  end

endmodule

[rtl/cwlp_div.sv]
// ---------------------------------------------------------------------------
// cwlp_div
// pipelined restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
module cwlp_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  cwlp_pkg::merge_out_t  merged,
  output logic                  done,
  output cwlp_pkg::result_t     result
);

  localparam int STAGES = cwlp_pkg::POS_W;

  cwlp_pkg::div_stage_t stg [STAGES+1];
  logic                 vld [STAGES+1];

  always_comb begin
    stg[0].rem     = merged.msum;
    stg[0].divisor = merged.wsum;
    stg[0].quot    = '0;
    stg[0].found   = merged.found;
    stg[0].green   = merged.green;
    stg[0].brown   = merged.brown;
    vld[0]         = in_valid;
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int BIT = STAGES - 1 - k;

    logic [cwlp_pkg::DIV_W-1:0] rem_ext;
    logic [cwlp_pkg::DIV_W-1:0] trial;
    logic                       ge;
    cwlp_pkg::div_stage_t       stg_next;

    // quotient stays below 2**POS_W, so the remainder fits each trial
    assign rem_ext = cwlp_pkg::DIV_W'(stg[k].rem);
    assign trial   = cwlp_pkg::DIV_W'(stg[k].divisor) << BIT;
    assign ge      = rem_ext >= trial;

    always_comb begin
      stg_next = stg[k];
      if (ge) begin
        stg_next.rem = cwlp_pkg::MSUM_W'(rem_ext - trial);
      end
      stg_next.quot[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      stg[k+1] <= stg_next;
    end
  end

  assign done              = vld[STAGES];
  assign result.position   = stg[STAGES].found ? stg[STAGES].quot : '0;
  assign result.line_found = stg[STAGES].found;
  assign result.green_line = stg[STAGES].green;
  assign result.brown_seen = stg[STAGES].brown;

endmodule

[rtl/cwlp_checker.sv]
// ---------------------------------------------------------------------------
// cwlp_checker
// port-level checks on results and frame transfers
// ---------------------------------------------------------------------------
`include "color_window_line_position_assert.svh"

module cwlp_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               done,
  input  cwlp_pkg::result_t  result
);

  localparam logic [cwlp_pkg::POS_W-1:0] POS_MIN =
    cwlp_pkg::POS_W'(cwlp_pkg::SPACING);
  localparam logic [cwlp_pkg::POS_W-1:0] POS_MAX =
    cwlp_pkg::POS_W'(cwlp_pkg::MAX_SENSORS * cwlp_pkg::SPACING);

  // no line means position zero
  `CWLP_ASSERT_IMP(a_no_line_zero, done && !result.line_found, result.position == '0, "position set without a line")

  // a found line lies between the first and last sensor place
  `CWLP_ASSERT_IMP(a_pos_range, done && result.line_found, result.position >= POS_MIN && result.position <= POS_MAX, "position outside sensor span")

  // every result goes back to a frame transfer a fixed latency earlier
  `CWLP_ASSERT_IMP(a_done_latency, done, $past(start && !busy, cwlp_pkg::LATENCY), "result without a frame transfer")

  // a transfer never blocks the next frame
  `CWLP_ASSERT_NXT(a_back_to_back, start && !busy, !busy, "busy raised after a transfer")

endmodule

bind color_window_line_position cwlp_checker u_checker (.*);

[test/cwlp_result_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cwlp_result_checker
// watches the frame, result and configuration channels of the colour window
// line position block, works out each expected result and compares it
// ---------------------------------------------------------------------------
module cwlp_result_checker #(
  parameter int NUM_SENSORS = 5
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   busy,
  input  cwlp_pkg::frame_t                       frame,
  input  logic                                   done,
  input  cwlp_pkg::result_t                      result,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [cwlp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cwlp_pkg::CFG_DATA_W-1:0]        cfg_data,
  output int                                     mismatches,
  output int                                     outstanding
);

  // own copy of the window registers
  logic [cwlp_pkg::BOUND_W-1:0] black_lo;
  logic [cwlp_pkg::BOUND_W-1:0] black_hi;
  logic [cwlp_pkg::PACK_W-1:0]  green_lo_pk;
  logic [cwlp_pkg::PACK_W-1:0]  green_hi_pk;
  logic [cwlp_pkg::PACK_W-1:0]  brown_lo_pk;
  logic [cwlp_pkg::PACK_W-1:0]  brown_hi_pk;

  cwlp_pkg::result_t positions_due[$];
  cwlp_pkg::result_t want;
  int                fail_count = 0;
  int                queued = 0;

  assign mismatches  = fail_count;
  assign outstanding = queued;

  // weighted centroid of one frame under the current windows
  function automatic cwlp_pkg::result_t centroid_of(cwlp_pkg::frame_t f);
    logic [cwlp_pkg::SENSOR_W-1:0] reading [cwlp_pkg::MAX_SENSORS];
    logic [cwlp_pkg::BOUND_W-1:0]  g_lo, g_hi, b_lo, b_hi;
    logic                          is_black, is_green, hit;
    longint unsigned               weight, wsum, msum;
    cwlp_pkg::result_t             r;
    reading[0] = f.sensor_0;
    reading[1] = f.sensor_1;
    reading[2] = f.sensor_2;
    reading[3] = f.sensor_3;
    reading[4] = f.sensor_4;
    wsum = 0;
    msum = 0;
    hit  = 1'b0;
    r    = '0;
    r.brown_seen = 1'b1;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      g_lo = green_lo_pk[cwlp_pkg::BOUND_W*i +: cwlp_pkg::BOUND_W];
      g_hi = green_hi_pk[cwlp_pkg::BOUND_W*i +: cwlp_pkg::BOUND_W];
      b_lo = brown_lo_pk[cwlp_pkg::BOUND_W*i +: cwlp_pkg::BOUND_W];
      b_hi = brown_hi_pk[cwlp_pkg::BOUND_W*i +: cwlp_pkg::BOUND_W];
      is_black = (reading[i] >= black_lo) && (reading[i] <= black_hi);
      is_green = (reading[i] >= g_lo) && (reading[i] <= g_hi);
      if (!((reading[i] >= b_lo) && (reading[i] <= b_hi)))
        r.brown_seen = 1'b0;
      if (is_black || is_green) begin
        weight = 64'(reading[i]);
        if (is_green) begin
          r.green_line = 1'b1;
          // outer sensors pull harder on green
          if (i == 0 || i == NUM_SENSORS - 1)
            weight = weight * cwlp_pkg::EDGE_GAIN;
        end
        wsum += weight;
        msum += weight * (i + 1) * cwlp_pkg::SPACING;
        hit = 1'b1;
      end
    end
    r.line_found = hit && (wsum != 0);
    if (r.line_found)
      r.position = cwlp_pkg::POS_W'(msum / wsum);
    return r;
  endfunction

  task automatic check_field(input string what, input int wanted, input int got);
    if (wanted != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, wanted, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      black_lo    <= cwlp_pkg::BLACK_LOW_RESET;
      black_hi    <= cwlp_pkg::BLACK_HIGH_RESET;
      green_lo_pk <= '0;
      green_hi_pk <= '0;
      brown_lo_pk <= '0;
      brown_hi_pk <= '0;
      positions_due.delete();
      queued <= 0;
    end else begin
      // prediction uses the windows in force before this edge
      if (start && !busy)
        positions_due.push_back(centroid_of(frame));
      if (done) begin
        if (positions_due.size() == 0) begin
          $display("%0t ns: result with nothing expected, actual %p", $time, result);
          fail_count++;
        end else begin
          want = positions_due.pop_front();
          check_field("position", int'(want.position), int'(result.position));
          check_field("line_found", int'(want.line_found), int'(result.line_found));
          check_field("green_line", int'(want.green_line), int'(result.green_line));
          check_field("brown_seen", int'(want.brown_seen), int'(result.brown_seen));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cwlp_pkg::CFG_BLACK_LOW:       black_lo    <= cfg_data[cwlp_pkg::BOUND_W-1:0];
          cwlp_pkg::CFG_BLACK_HIGH:      black_hi    <= cfg_data[cwlp_pkg::BOUND_W-1:0];
          cwlp_pkg::CFG_GREEN_LOW_PACK:  green_lo_pk <= cfg_data;
          cwlp_pkg::CFG_GREEN_HIGH_PACK: green_hi_pk <= cfg_data;
          cwlp_pkg::CFG_BROWN_LOW_PACK:  brown_lo_pk <= cfg_data;
          cwlp_pkg::CFG_BROWN_HIGH_PACK: brown_hi_pk <= cfg_data;
          default: ;
        endcase
      end
      queued <= positions_due.size();
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// frames and window settings for the colour window line position block; a
// checker beside the block predicts every result and compares it
// ---------------------------------------------------------------------------
module testbench;

  localparam int NSENS       = 5;
  localparam int RANDOM_GOAL = 1400;
  localparam int QUIET_TAIL  = 200;   // last frames go back to back
  localparam int DRAIN_LIMIT = 1000;

  // register slots past the last window register, writes there are dropped
  localparam logic [cwlp_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [cwlp_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam logic [cwlp_pkg::PACK_W-1:0]  PACK_ONES = {cwlp_pkg::PACK_W{1'b1}};
  localparam logic [cwlp_pkg::BOUND_W-1:0] BOUND_MAX = {cwlp_pkg::BOUND_W{1'b1}};

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  cwlp_pkg::frame_t                frame = '0;
  logic                            done;
  cwlp_pkg::result_t               result;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [cwlp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cwlp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;

  // windows as last written, used only to aim the stimulus
  logic [cwlp_pkg::BOUND_W-1:0] black_lo_set = cwlp_pkg::BLACK_LOW_RESET;
  logic [cwlp_pkg::BOUND_W-1:0] black_hi_set = cwlp_pkg::BLACK_HIGH_RESET;
  logic [cwlp_pkg::PACK_W-1:0]  green_lo_set = '0;
  logic [cwlp_pkg::PACK_W-1:0]  green_hi_set = '0;
  logic [cwlp_pkg::PACK_W-1:0]  brown_lo_set = '0;
  logic [cwlp_pkg::PACK_W-1:0]  brown_hi_set = '0;

  bit idling = 1'b0;

  color_window_line_position #(.NUM_SENSORS(NSENS)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .frame     (frame),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cwlp_result_checker #(.NUM_SENSORS(NSENS)) u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .frame       (frame),
    .done        (done),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic cwlp_pkg::frame_t frame_of(int a, int b, int c, int d, int e);
    cwlp_pkg::frame_t f;
    f.sensor_0 = a[cwlp_pkg::SENSOR_W-1:0];
    f.sensor_1 = b[cwlp_pkg::SENSOR_W-1:0];
    f.sensor_2 = c[cwlp_pkg::SENSOR_W-1:0];
    f.sensor_3 = d[cwlp_pkg::SENSOR_W-1:0];
    f.sensor_4 = e[cwlp_pkg::SENSOR_W-1:0];
    return f;
  endfunction

  // one frame transfer; start stays high unless a random gap lowers it, so the next call can follow at once
  task automatic push_frame(input cwlp_pkg::frame_t f);
    start <= 1'b1;
    frame <= f;
    do @(posedge clk); while (busy);
    // random gap after the transfer, only while idling is enabled
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      frame <= frame_of($urandom, $urandom, $urandom, $urandom, $urandom);
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (cwlp_pkg::LATENCY) @(posedge clk);
  endtask

  // register write transfer; valid is left high unless a random gap lowers it, else the caller lowers it
  task automatic write_reg(input logic [cwlp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cwlp_pkg::PACK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idling && $urandom_range(0, 2) == 0) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // push the whole window set; junk rides above the 11-bit black bounds
  task automatic load_windows(input bit with_spares);
    logic [cwlp_pkg::PACK_W-1:0] junk;
    junk = cwlp_pkg::PACK_W'({$urandom, $urandom});
    write_reg(cwlp_pkg::CFG_BLACK_LOW,
              {junk[cwlp_pkg::PACK_W-1:cwlp_pkg::BOUND_W], black_lo_set});
    junk = cwlp_pkg::PACK_W'({$urandom, $urandom});
    write_reg(cwlp_pkg::CFG_BLACK_HIGH,
              {junk[cwlp_pkg::PACK_W-1:cwlp_pkg::BOUND_W], black_hi_set});
    write_reg(cwlp_pkg::CFG_GREEN_LOW_PACK, green_lo_set);
    write_reg(cwlp_pkg::CFG_GREEN_HIGH_PACK, green_hi_set);
    write_reg(cwlp_pkg::CFG_BROWN_LOW_PACK, brown_lo_set);
    write_reg(cwlp_pkg::CFG_BROWN_HIGH_PACK, brown_hi_set);
    if (with_spares) begin
      write_reg(CFG_SPARE_6, cwlp_pkg::PACK_W'({$urandom, $urandom}));
      write_reg(CFG_SPARE_7, cwlp_pkg::PACK_W'({$urandom, $urandom}));
    end
    cfg_valid <= 1'b0;
  endtask

  // one window: empty, full, a single point, unreachable, or a random span
  task automatic rand_window(output logic [cwlp_pkg::BOUND_W-1:0] lo,
                             output logic [cwlp_pkg::BOUND_W-1:0] hi);
    int a, b;
    case ($urandom_range(0, 9))
      0: begin
        a = $urandom_range(1, 2047);
        b = $urandom_range(0, a - 1);
      end
      1: begin
        a = 0;
        b = 2047;
      end
      2: begin
        a = $urandom_range(0, 1023);
        b = a;
      end
      3: begin
        a = 2047;
        b = 2047;
      end
      4: begin
        a = 0;
        b = 0;
      end
      default: begin
        a = $urandom_range(0, 1100);
        b = $urandom_range(0, 1100);
        if (a > b) begin
          a = a + b;
          b = a - b;
          a = a - b;
        end
      end
    endcase
    lo = a[cwlp_pkg::BOUND_W-1:0];
    hi = b[cwlp_pkg::BOUND_W-1:0];
  endtask

  task automatic rand_packs(output logic [cwlp_pkg::PACK_W-1:0] lo_pk,
                            output logic [cwlp_pkg::PACK_W-1:0] hi_pk);
    logic [cwlp_pkg::BOUND_W-1:0] lo, hi;
    for (int s = 0; s < cwlp_pkg::MAX_SENSORS; s++) begin
      rand_window(lo, hi);
      lo_pk[cwlp_pkg::BOUND_W*s +: cwlp_pkg::BOUND_W] = lo;
      hi_pk[cwlp_pkg::BOUND_W*s +: cwlp_pkg::BOUND_W] = hi;
    end
  endtask

  // a reading for sensor s: plain noise, inside its brown window, or near
  // one of the bounds that apply to it
  function automatic logic [cwlp_pkg::SENSOR_W-1:0] pick_reading(int s, int kind);
    int v, lo, hi, nudge;
    v = $urandom_range(0, 1023);
    if (kind == 1) begin
      lo = int'(brown_lo_set[cwlp_pkg::BOUND_W*s +: cwlp_pkg::BOUND_W]);
      hi = int'(brown_hi_set[cwlp_pkg::BOUND_W*s +: cwlp_pkg::BOUND_W]);
      if (hi > 1023) hi = 1023;
      if (lo <= hi) v = $urandom_range(lo, hi);
    end else if (kind == 2) begin
      nudge = $urandom_range(0, 2);
      case ($urandom_range(0, 7))
        0: v = int'(black_lo_set);
        1: v = int'(black_hi_set);
        2: v = int'(green_lo_set[cwlp_pkg::BOUND_W*s +: cwlp_pkg::BOUND_W]);
        3: v = int'(green_hi_set[cwlp_pkg::BOUND_W*s +: cwlp_pkg::BOUND_W]);
        4: v = int'(brown_lo_set[cwlp_pkg::BOUND_W*s +: cwlp_pkg::BOUND_W]);
        5: v = int'(brown_hi_set[cwlp_pkg::BOUND_W*s +: cwlp_pkg::BOUND_W]);
        6: v = 0;
        default: ;
      endcase
      v = v + nudge - 1;
    end
    if (v < 0) v = 0;
    if (v > 1023) v = $urandom_range(0, 1023);
    return v[cwlp_pkg::SENSOR_W-1:0];
  endfunction

  function automatic cwlp_pkg::frame_t random_frame();
    int kind;
    int r [cwlp_pkg::MAX_SENSORS];
    case ($urandom_range(0, 19))
      0, 1, 2:    kind = 0;
      3, 4, 5, 6: kind = 1;
      default:    kind = 2;
    endcase
    for (int s = 0; s < cwlp_pkg::MAX_SENSORS; s++)
      r[s] = pick_reading(s, kind);
    return frame_of(r[0], r[1], r[2], r[3], r[4]);
  endfunction

  initial begin
    int sent;
    int run_len;
    int waited;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed, reset windows: black 300..1500, green and brown 0..0 ----
    idling = 1'b1;
    push_frame(frame_of(0, 0, 0, 0, 0));          // zero weights, green and brown set
    push_frame(frame_of(1023, 1023, 1023, 1023, 1023));
    push_frame(frame_of(300, 300, 300, 300, 300));  // on the lower black bound
    push_frame(frame_of(299, 299, 299, 299, 299));  // just outside, no line
    push_frame(frame_of(1000, 0, 0, 0, 0));
    push_frame(frame_of(0, 1000, 0, 0, 0));
    push_frame(frame_of(0, 0, 1000, 0, 0));
    push_frame(frame_of(0, 0, 0, 1000, 0));
    push_frame(frame_of(0, 0, 0, 0, 1000));
    push_frame(frame_of(300, 1023, 0, 512, 299));
    push_frame(frame_of(0, 1023, 1023, 1023, 1023));
    push_frame(frame_of(1001, 301, 1022, 700, 1));  // mixed readings, the last outside every window

    // ---- every reading green, black only at zero, brown unreachable ----
    wait_quiet();
    black_lo_set = '0;
    black_hi_set = '0;
    green_lo_set = '0;
    green_hi_set = PACK_ONES;
    brown_lo_set = PACK_ONES;
    brown_hi_set = PACK_ONES;
    load_windows(1'b1);
    push_frame(frame_of(1000, 1000, 1000, 1000, 1000));  // outer gain, centred
    push_frame(frame_of(1023, 0, 0, 0, 0));
    push_frame(frame_of(1, 0, 0, 0, 1023));
    push_frame(frame_of(0, 0, 0, 0, 0));
    push_frame(frame_of(0, 1023, 0, 1023, 0));

    // ---- empty black and green windows (low above high), brown everything ----
    wait_quiet();
    black_lo_set = BOUND_MAX;
    black_hi_set = '0;
    green_lo_set = PACK_ONES;
    green_hi_set = '0;
    brown_lo_set = '0;
    brown_hi_set = PACK_ONES;
    load_windows(1'b0);
    push_frame(frame_of(1023, 512, 0, 300, 1000));
    push_frame(frame_of(0, 0, 0, 0, 0));
    push_frame(frame_of(1023, 1023, 1023, 1023, 1023));

    // ---- top black bound at its maximum ----
    wait_quiet();
    black_lo_set = BOUND_MAX;
    black_hi_set = BOUND_MAX;
    load_windows(1'b0);
    push_frame(frame_of(1023, 1023, 1023, 1023, 1023));

    // ---- random phases: new windows, then a run of aimed frames ----
    sent = 0;
    while (sent < RANDOM_GOAL) begin
      wait_quiet();
      idling = (sent < RANDOM_GOAL - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      rand_window(black_lo_set, black_hi_set);
      rand_packs(green_lo_set, green_hi_set);
      rand_packs(brown_lo_set, brown_hi_set);
      load_windows($urandom_range(0, 3) == 0);
      run_len = $urandom_range(20, 80);
      for (int k = 0; k < run_len && sent < RANDOM_GOAL; k++) begin
        push_frame(random_frame());
        sent++;
      end
    end

    // ---- drain and verdict ----
    start <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (cwlp_pkg::LATENCY + 4) @(posedge clk);
    if (outstanding != 0)
      $display("%0t ns: %0d results never arrived", $time, outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
